### sv/bpc_pkg.sv
// Shared widths, register indexes and compensation constants for the barometer compensator.
package bpc_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_CAL_A = 3'd0,
		CFG_CAL_B = 3'd1,
		CFG_CAL_C = 3'd2,
		CFG_OSS   = 3'd3
	} cfg_idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// Temperature divide: |mc << 11| below 2^27, |x1 + md| below 2^18
	localparam int TDIV_NUM_W = 27;
	localparam int TDIV_DEN_W = 18;
	// Pressure divide: b7 is a full word, b4 below 2^17
	localparam int PDIV_NUM_W = 32;
	localparam int PDIV_DEN_W = 17;

	localparam logic signed [31:0] B6_OFFSET = 32'sd4000;
	localparam logic        [31:0] B4_BIAS   = 32'd32768;
	localparam logic        [15:0] B7_SCALE  = 16'd50000;
	localparam logic signed [31:0] P_C1      = 32'sd3038;
	localparam logic signed [31:0] P_C2      = -32'sd7357;
	localparam logic signed [31:0] P_C3      = 32'sd3791;

	localparam logic signed [31:0] T_MAX = 32'sd4095;
	localparam logic signed [31:0] T_MIN = -32'sd4096;
	localparam logic signed [31:0] P_MAX = 32'sd131071;

endpackage

### sv/bpc_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage, with a tag riding along.
module bpc_div_pipe #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 17,
	parameter int TAG_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] tag,
	output logic             out_valid,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem,
	output logic [TAG_W-1:0] out_tag
);

	logic             v_q   [NUM_W];
	logic [NUM_W-1:0] num_q [NUM_W];
	logic [DEN_W-1:0] den_q [NUM_W];
	logic [DEN_W-1:0] rem_q [NUM_W];
	logic [TAG_W-1:0] tag_q [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic             v_i;
		logic [NUM_W-1:0] num_i;
		logic [DEN_W-1:0] den_i;
		logic [DEN_W-1:0] rem_i;
		logic [TAG_W-1:0] tag_i;
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   diff;
		logic             ge;

		if (k == 0) begin : g_first
			assign v_i   = in_valid;
			assign num_i = num;
			assign den_i = den;
			assign rem_i = '0;
			assign tag_i = tag;
		end else begin : g_next
			assign v_i   = v_q[k-1];
			assign num_i = num_q[k-1];
			assign den_i = den_q[k-1];
			assign rem_i = rem_q[k-1];
			assign tag_i = tag_q[k-1];
		end

		// Shift in the next numerator bit and try to subtract
		assign trial = {rem_i, num_i[NUM_W-1]};
		assign diff  = trial - {1'b0, den_i};
		assign ge    = (trial >= {1'b0, den_i});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else begin
				v_q[k] <= v_i;
			end
		end

		// Advance payload; quotient bits fill in as numerator bits leave
		always_ff @(posedge clk) begin
			num_q[k] <= {num_i[NUM_W-2:0], ge};
			den_q[k] <= den_i;
			rem_q[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			tag_q[k] <= tag_i;
		end
	end

	assign out_valid = v_q[NUM_W-1];
	assign quo       = num_q[NUM_W-1];
	assign rem       = rem_q[NUM_W-1];
	assign out_tag   = tag_q[NUM_W-1];

endmodule

### sv/baro_temp_pressure_compensation.sv
// Top level of the barometer temperature and pressure compensator.
//
//  channel   | signals                                     | handshake
//  ----------+---------------------------------------------+--------------------------
//  sample in | start, busy, raw_temperature, raw_pressure  | start && !busy
//  result    | done, temperature_tenths, pressure_pa,      | done, one cycle, no stall
//            | divide_fault                                |
//  config    | cfg_valid, cfg_ready, cfg_index, cfg_data   | cfg_valid && cfg_ready
//
// One word enters per cycle; busy stays low. Each result follows its start through
// two one-bit-per-stage dividers (27 and 32 stages) plus the multiply stages around
// them. Reset clears the valid bits and the calibration.
// The result side cannot stall, so the pipeline advances every cycle.
module baro_temp_pressure_compensation (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [15:0]                     raw_temperature,
	input  logic [18:0]                     raw_pressure,
	output logic                            done,
	output logic signed [12:0]              temperature_tenths,
	output logic [16:0]                     pressure_pa,
	output logic                            divide_fault,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bpc_pkg::*;

	localparam int TTAG_W = 2 + 32 + 19;
	localparam int PTAG_W = 1 + 13 + 1 + PDIV_DEN_W;

	logic [63:0] cal_a_q;
	logic [63:0] cal_b_q;
	logic [31:0] cal_c_q;
	logic [1:0]  oss_q;

	logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
	logic        [15:0] ac4, ac5, ac6;

	assign ac1 = cal_a_q[63:48];
	assign ac2 = cal_a_q[47:32];
	assign ac3 = cal_a_q[31:16];
	assign ac4 = cal_a_q[15:0];
	assign ac5 = cal_b_q[63:48];
	assign ac6 = cal_b_q[47:32];
	assign b1  = cal_b_q[31:16];
	assign b2  = cal_b_q[15:0];
	assign mc  = cal_c_q[31:16];
	assign md  = cal_c_q[15:0];

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	// Write calibration; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_a_q <= '0;
			cal_b_q <= '0;
			cal_c_q <= '0;
			oss_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CAL_A: cal_a_q <= cfg_data;
				CFG_CAL_B: cal_b_q <= cfg_data;
				CFG_CAL_C: cal_c_q <= cfg_data[31:0];
				CFG_OSS:   oss_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// ---------------- valid chain ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic tdiv_v, pdiv_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0; done <= 1'b0;
		end else begin
			v_s1  <= start && !busy;
			v_s2  <= v_s1;
			v_s3  <= tdiv_v;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= pdiv_v;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			done  <= v_s11;
		end
	end

	// ---------------- stage 1: (ut - ac6) * ac5 ----------------
	logic signed [16:0] dt;
	logic signed [33:0] p1_full;
	logic [31:0]        p1_s1;
	logic [18:0]        up_s1;

	always_comb begin
		dt      = $signed({1'b0, raw_temperature}) - $signed({1'b0, ac6});
		p1_full = dt * $signed({1'b0, ac5});
	end

	always_ff @(posedge clk) begin
		p1_s1 <= p1_full[31:0];
		up_s1 <= raw_pressure;
	end

	// ---------------- stage 2: x1, divisor and magnitudes ----------------
	logic signed [31:0] x1_c, den_c, mcs_c;
	logic        [31:0] nmag_c, dmag_c;
	logic signed [31:0] x1_s2;
	logic [18:0]        up_s2;
	logic               dz_s2, qneg_s2;
	logic [TDIV_NUM_W-1:0] tnum_s2;
	logic [TDIV_DEN_W-1:0] tden_s2;

	always_comb begin
		x1_c   = $signed(p1_s1) >>> 15;
		den_c  = x1_c + 32'(md);
		mcs_c  = 32'(mc) <<< 11;
		nmag_c = mcs_c[31] ? 32'(-mcs_c) : mcs_c;
		dmag_c = den_c[31] ? 32'(-den_c) : den_c;
	end

	always_ff @(posedge clk) begin
		x1_s2   <= x1_c;
		up_s2   <= up_s1;
		dz_s2   <= (den_c == '0);
		qneg_s2 <= mcs_c[31] ^ den_c[31];
		tnum_s2 <= nmag_c[TDIV_NUM_W-1:0];
		tden_s2 <= dmag_c[TDIV_DEN_W-1:0];
	end

	// ---------------- temperature divide ----------------
	logic [TDIV_NUM_W-1:0] tq;
	logic [TDIV_DEN_W-1:0] trem;
	logic [TTAG_W-1:0]     ttag_out;

	bpc_div_pipe #(
		.NUM_W(TDIV_NUM_W),
		.DEN_W(TDIV_DEN_W),
		.TAG_W(TTAG_W)
	) u_tdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s2),
		.num      (tnum_s2),
		.den      (tden_s2),
		.tag      ({dz_s2, qneg_s2, x1_s2, up_s2}),
		.out_valid(tdiv_v),
		.quo      (tq),
		.rem      (trem),
		.out_tag  (ttag_out)
	);

	// ---------------- stage 3: b5, b6, temperature ----------------
	logic               td_fault, td_qneg;
	logic signed [31:0] td_x1, x2_c, b5_c, tv_c;
	logic [18:0]        td_up;
	logic [12:0]        t_c;
	logic signed [31:0] b6_s3;
	logic [12:0]        t_s3;
	logic               f_s3;
	logic [18:0]        up_s3;

	assign {td_fault, td_qneg, td_x1, td_up} = ttag_out;

	always_comb begin
		x2_c = td_qneg ? -$signed(32'(tq)) : $signed(32'(tq));
		b5_c = td_x1 + x2_c;
		tv_c = (b5_c + 32'sd8) >>> 4;
		if (tv_c > T_MAX) begin
			t_c = T_MAX[12:0];
		end else if (tv_c < T_MIN) begin
			t_c = T_MIN[12:0];
		end else begin
			t_c = tv_c[12:0];
		end
	end

	always_ff @(posedge clk) begin
		b6_s3 <= b5_c - B6_OFFSET;
		t_s3  <= t_c;
		f_s3  <= td_fault || (|trem && 1'b0);
		up_s3 <= td_up;
	end

	// ---------------- stage 4: b6 products ----------------
	logic signed [63:0] sq_full, a2_full, a3_full;
	logic signed [31:0] sq_s4, a2_s4, a3_s4;
	logic [12:0] t_s4;
	logic        f_s4;
	logic [18:0] up_s4;

	always_comb begin
		sq_full = b6_s3 * b6_s3;
		a2_full = 64'(b6_s3 * $signed(32'(ac2)));
		a3_full = 64'(b6_s3 * $signed(32'(ac3)));
	end

	always_ff @(posedge clk) begin
		sq_s4 <= sq_full[31:0];
		a2_s4 <= a2_full[31:0];
		a3_s4 <= a3_full[31:0];
		t_s4  <= t_s3;
		f_s4  <= f_s3;
		up_s4 <= up_s3;
	end

	// ---------------- stage 5: b1, b2 terms ----------------
	logic signed [31:0] sq12_c;
	logic signed [47:0] b2m_full, b1m_full;
	logic signed [31:0] b2m_s5, b1m_s5, m2_s5, m3_s5;
	logic [12:0] t_s5;
	logic        f_s5;
	logic [18:0] up_s5;

	always_comb begin
		sq12_c   = sq_s4 >>> 12;
		b2m_full = sq12_c * b2;
		b1m_full = sq12_c * b1;
	end

	always_ff @(posedge clk) begin
		b2m_s5 <= b2m_full[31:0];
		b1m_s5 <= b1m_full[31:0];
		m2_s5  <= a2_s4 >>> 11;
		m3_s5  <= a3_s4 >>> 13;
		t_s5   <= t_s4;
		f_s5   <= f_s4;
		up_s5  <= up_s4;
	end

	// ---------------- stage 6: b3 and x3 ----------------
	logic signed [31:0] x3p_c, b3a_c, b3b_c, y_c;
	logic signed [31:0] b3_s6, y_s6;
	logic [12:0] t_s6;
	logic        f_s6;
	logic [18:0] up_s6;

	always_comb begin
		x3p_c = (b2m_s5 >>> 11) + m2_s5;
		b3a_c = ($signed(32'(ac1)) <<< 2) + x3p_c;
		b3b_c = (b3a_c <<< oss_q) + 32'sd2;
		y_c   = (m3_s5 + (b1m_s5 >>> 16) + 32'sd2) >>> 2;
	end

	always_ff @(posedge clk) begin
		b3_s6 <= b3b_c >>> 2;
		y_s6  <= y_c;
		t_s6  <= t_s5;
		f_s6  <= f_s5;
		up_s6 <= up_s5;
	end

	// ---------------- stage 7: b4 and b7 products ----------------
	logic [47:0] b4p_full, b7_full;
	logic [31:0] b4p_s7, b7_s7;
	logic [12:0] t_s7;
	logic        f_s7;

	always_comb begin
		b4p_full = ac4 * (y_s6 + B4_BIAS);
		b7_full  = (32'(up_s6) - b3_s6) * (B7_SCALE >> oss_q);
	end

	always_ff @(posedge clk) begin
		b4p_s7 <= b4p_full[31:0];
		b7_s7  <= b7_full[31:0];
		t_s7   <= t_s6;
		f_s7   <= f_s6;
	end

	// ---------------- stage 8: divisor check ----------------
	logic [PDIV_DEN_W-1:0] b4_s8;
	logic [31:0]           b7_s8;
	logic [12:0]           t_s8;
	logic                  f_s8;

	always_ff @(posedge clk) begin
		b4_s8 <= b4p_s7[31:15];
		b7_s8 <= b7_s7;
		t_s8  <= t_s7;
		f_s8  <= f_s7 || (b4p_s7[31:15] == '0);
	end

	// ---------------- pressure divide ----------------
	logic [PDIV_NUM_W-1:0] pq;
	logic [PDIV_DEN_W-1:0] prem;
	logic [PTAG_W-1:0]     ptag_out;

	bpc_div_pipe #(
		.NUM_W(PDIV_NUM_W),
		.DEN_W(PDIV_DEN_W),
		.TAG_W(PTAG_W)
	) u_pdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s8),
		.num      (b7_s8),
		.den      (b4_s8),
		.tag      ({f_s8, t_s8, b7_s8[31], b4_s8}),
		.out_valid(pdiv_v),
		.quo      (pq),
		.rem      (prem),
		.out_tag  (ptag_out)
	);

	// ---------------- stage 9: double the quotient ----------------
	logic                  pd_fault, pd_big;
	logic [12:0]           pd_t;
	logic [PDIV_DEN_W-1:0] pd_b4;
	logic                  rbit_c;
	logic signed [31:0]    p_s9;
	logic [12:0]           t_s9;
	logic                  f_s9;

	assign {pd_fault, pd_t, pd_big, pd_b4} = ptag_out;
	assign rbit_c = ({prem, 1'b0} >= {1'b0, pd_b4});

	always_ff @(posedge clk) begin
		p_s9 <= {pq[30:0], pd_big ? 1'b0 : rbit_c};
		t_s9 <= pd_t;
		f_s9 <= pd_fault;
	end

	// ---------------- stage 10: correction products ----------------
	logic signed [31:0] p8_c;
	logic signed [63:0] pa_full, pb_full;
	logic signed [31:0] p_s10, pa_s10, pb_s10;
	logic [12:0] t_s10;
	logic        f_s10;

	always_comb begin
		p8_c    = p_s9 >>> 8;
		pa_full = p8_c * p8_c;
		pb_full = p_s9 * P_C2;
	end

	always_ff @(posedge clk) begin
		p_s10  <= p_s9;
		pa_s10 <= pa_full[31:0];
		pb_s10 <= $signed(pb_full[31:0]) >>> 16;
		t_s10  <= t_s9;
		f_s10  <= f_s9;
	end

	// ---------------- stage 11: scale x1 ----------------
	logic signed [63:0] pc_full;
	logic signed [31:0] p_s11, pc_s11, pb_s11;
	logic [12:0] t_s11;
	logic        f_s11;

	assign pc_full = pa_s10 * P_C1;

	always_ff @(posedge clk) begin
		p_s11  <= p_s10;
		pc_s11 <= $signed(pc_full[31:0]) >>> 16;
		pb_s11 <= pb_s10;
		t_s11  <= t_s10;
		f_s11  <= f_s10;
	end

	// ---------------- stage 12: final sum, clamp, output ----------------
	logic signed [31:0] pf_c;
	logic [16:0]        pcl_c;

	always_comb begin
		pf_c = p_s11 + ((pc_s11 + pb_s11 + P_C3) >>> 4);
		if (pf_c < 32'sd0) begin
			pcl_c = '0;
		end else if (pf_c > P_MAX) begin
			pcl_c = P_MAX[16:0];
		end else begin
			pcl_c = pf_c[16:0];
		end
	end

	always_ff @(posedge clk) begin
		temperature_tenths <= f_s11 ? '0 : $signed(t_s11);
		pressure_pa        <= f_s11 ? '0 : pcl_c;
		divide_fault       <= f_s11;
	end

	// ---------------- checks ----------------
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && divide_fault |-> temperature_tenths == '0 && pressure_pa == '0)
		else $error("fault word carries nonzero fields");

	a_zero_b4: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 && b4_s8 == '0 |-> f_s8)
		else $error("zero pressure divisor not flagged");

	a_pdiv_lat: assert property (@(posedge clk) disable iff (!arst_n)
		pdiv_v |-> $past(v_s8, PDIV_NUM_W))
		else $error("pressure divider word without entry");

	a_tdiv_lat: assert property (@(posedge clk) disable iff (!arst_n)
		tdiv_v |-> $past(v_s2, TDIV_NUM_W))
		else $error("temperature divider word without entry");

endmodule
